// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the growable slot table.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_NEXT(label, clk, rst, trig, cond, msg)

`endif

`endif

// ===== rtl/gst_pkg.sv =====
// Package for the growable slot table: operation and status codes,
// the stored word type and fixed constants. No dependencies.
package gst_pkg;

   typedef logic signed [31:0] slot_word_type;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_READ   = 2'd2;

   localparam logic [2:0] STATUS_OK       = 3'd0;
   localparam logic [2:0] STATUS_DROPPED  = 3'd1;
   localparam logic [2:0] STATUS_EMPTY    = 3'd2;
   localparam logic [2:0] STATUS_FREE     = 3'd3;
   localparam logic [2:0] STATUS_RANGE    = 3'd4;

   localparam int BASE_CAPACITY = 5;

   // A free slot holds all ones; live values never have the top bit set.
   localparam slot_word_type FREE_WORD  = '1;
   localparam slot_word_type ZERO_WORD  = '0;

endpackage

// ===== rtl/growable_slot_table.sv =====
// Top level of the growable slot table: slot memory, capacity and count
// registers and the sequencer that scans, packs and refills the memory.
// Depends on gst_pkg and assert_macros.svh.
//
//  Channel   Ports                                   Handshake
//  request   req_opcode, req_item_value,             start high while busy low
//            req_slot_position
//  response  rsp_result_value, rsp_status,           rsp_strobe, one cycle
//            rsp_capacity_now, rsp_count_now
//
// After reset the memory is cleared with busy high.
// Empty, out-of-range, dropped and full-table adds answer in the cycle after the request is taken.
// Read and plain remove answer after one registered memory read.
// Add into a free slot scans from slot 0 for the first free slot.
// A remove that compacts walks the old capacity once and then refills
// GROW_STEP slots; capacity <= MAX_SLOTS.
// The single memory port pair paces each operation; results cannot be stalled.
`include "assert_macros.svh"

module growable_slot_table
   import gst_pkg::*;
#(
   parameter int MAX_SLOTS = 80,
   parameter int GROW_STEP = 5
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_opcode,
   input  logic [30:0]         req_item_value,
   input  logic [7:0]          req_slot_position,
   output logic                rsp_strobe,
   output logic signed [31:0]  rsp_result_value,
   output logic [2:0]          rsp_status,
   output logic [6:0]          rsp_capacity_now,
   output logic [6:0]          rsp_count_now
);

   localparam int CNT_W = $clog2(MAX_SLOTS + 1);
   localparam int IDX_W = $clog2(MAX_SLOTS);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_SCAN    = 3'd2;
   localparam logic [2:0] ST_POS_CHK = 3'd3;
   localparam logic [2:0] ST_PACK    = 3'd4;
   localparam logic [2:0] ST_FILL    = 3'd5;

   slot_word_type slot_mem [MAX_SLOTS];

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] src_ff, src_in;
   logic [IDX_W-1:0] dst_ff, dst_in;
   logic             pk_vld_ff, pk_vld_in;
   logic [1:0]       op_ff, op_in;
   logic [30:0]      val_ff, val_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   slot_word_type    rdata_ff;
   logic             rsp_strobe_ff, rsp_strobe_in;
   slot_word_type    rsp_value_ff, rsp_value_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   slot_word_type    wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;

   logic             accept;
   logic             pos_in_range;
   logic             table_full;
   logic             grow_blocked;
   logic             pack_done;

   assign accept       = start && !busy;
   assign pos_in_range = CMP_W'(req_slot_position) < CMP_W'(cap_ff);
   assign table_full   = cnt_ff >= cap_ff;
   assign grow_blocked = ({1'b0, cap_ff} + SUM_W'(GROW_STEP)) > SUM_W'(MAX_SLOTS);
   assign pack_done    = pk_vld_ff && (src_ff == cap_ff);

   always_comb begin
      state_in      = state_ff;
      cap_in        = cap_ff;
      cnt_in        = cnt_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      pk_vld_in     = pk_vld_ff;
      op_in         = op_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      rsp_strobe_in = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = FREE_WORD;
      rd_en         = 1'b0;
      rd_addr       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(src_ff);
            if (src_ff == CNT_W'(MAX_SLOTS - 1)) begin
               src_in   = '0;
               state_in = ST_IDLE;
            end else begin
               src_in = src_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (accept) begin
               op_in  = req_opcode;
               val_in = req_item_value;
               pos_in = IDX_W'(req_slot_position);
               rsp_value_in  = ZERO_WORD;
               rsp_status_in = STATUS_OK;
               unique case (req_opcode)
                  OP_ADD: begin
                     if (table_full && grow_blocked) begin
                        rsp_status_in = STATUS_DROPPED;
                        rsp_strobe_in = 1'b1;
                     end else if (table_full) begin
                        // Slots beyond the capacity are always free, so growing
                        // needs no write of its own: append at the count.
                        wr_en   = 1'b1;
                        wr_addr = IDX_W'(cnt_ff);
                        wr_data = {1'b0, req_item_value};
                        cap_in  = cap_ff + CNT_W'(GROW_STEP);
                        cnt_in  = cnt_ff + 1'b1;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        src_in   = '0;
                        state_in = ST_SCAN;
                     end
                  end
                  OP_REMOVE, OP_READ: begin
                     if (cnt_ff == '0) begin
                        rsp_value_in  = (req_opcode == OP_REMOVE) ? FREE_WORD : ZERO_WORD;
                        rsp_status_in = STATUS_EMPTY;
                        rsp_strobe_in = 1'b1;
                     end else if (!pos_in_range) begin
                        rsp_value_in  = (req_opcode == OP_REMOVE) ? ZERO_WORD : FREE_WORD;
                        rsp_status_in = STATUS_RANGE;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = IDX_W'(req_slot_position);
                        state_in = ST_POS_CHK;
                     end
                  end
                  default: begin
                     rsp_status_in = STATUS_RANGE;
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            // The read data belongs to slot src_ff; a free slot is certain
            // to turn up below the capacity.
            if (rdata_ff[31]) begin
               wr_en         = 1'b1;
               wr_addr       = IDX_W'(src_ff);
               wr_data       = {1'b0, val_ff};
               cnt_in        = cnt_ff + 1'b1;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = IDX_W'(src_ff + 1'b1);
               src_in  = src_ff + 1'b1;
            end
         end

         ST_POS_CHK: begin
            if (rdata_ff[31]) begin
               rsp_value_in  = FREE_WORD;
               rsp_status_in = STATUS_FREE;
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               rsp_value_in = rdata_ff;
               if (op_ff == OP_REMOVE) begin
                  wr_en   = 1'b1;
                  wr_addr = pos_ff;
                  cnt_in  = cnt_ff - 1'b1;
                  if ((cap_ff > CNT_W'(BASE_CAPACITY)) &&
                      (cnt_ff - 1'b1 == cap_ff - CNT_W'(GROW_STEP))) begin
                     src_in    = '0;
                     dst_in    = '0;
                     pk_vld_in = 1'b0;
                     state_in  = ST_PACK;
                  end else begin
                     rsp_strobe_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end else begin
                  rsp_strobe_in = 1'b1;
                  state_in      = ST_IDLE;
               end
            end
         end

         ST_PACK: begin
            // Reads run one slot ahead of the check; live entries are copied
            // down to dst_ff, which never passes the slot being read.
            if (!pack_done) begin
               rd_en     = 1'b1;
               rd_addr   = IDX_W'(src_ff);
               src_in    = src_ff + 1'b1;
               pk_vld_in = 1'b1;
            end
            if (pk_vld_ff && !rdata_ff[31]) begin
               wr_en   = 1'b1;
               wr_addr = dst_ff;
               wr_data = rdata_ff;
               dst_in  = dst_ff + 1'b1;
            end
            if (pack_done) begin
               state_in = ST_FILL;
            end
         end

         ST_FILL: begin
            // The slots from the new capacity up to the old one become free.
            wr_en   = 1'b1;
            wr_addr = dst_ff;
            if (CNT_W'(dst_ff) == cap_ff - 1'b1) begin
               cap_in        = cap_ff - CNT_W'(GROW_STEP);
               rsp_strobe_in = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               dst_in = dst_ff + 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         cap_ff        <= CNT_W'(BASE_CAPACITY);
         cnt_ff        <= '0;
         src_ff        <= '0;
         dst_ff        <= '0;
         pk_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cap_ff        <= cap_in;
         cnt_ff        <= cnt_in;
         src_ff        <= src_in;
         dst_ff        <= dst_in;
         pk_vld_ff     <= pk_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_capacity_now = 7'(cap_ff);
   assign rsp_count_now    = 7'(cnt_ff);

   `ASSERT_ALWAYS(a_count_le_cap, clock, reset, cnt_ff <= cap_ff, "gst: count above capacity")
   `ASSERT_ALWAYS(a_cap_bounds, clock, reset, (cap_ff >= CNT_W'(BASE_CAPACITY)) && (cap_ff <= CNT_W'(MAX_SLOTS)), "gst: capacity out of bounds")
   `ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_strobe, "gst: accepted item neither answered nor in work")
   `ASSERT_ALWAYS(a_pack_order, clock, reset, (state_ff != ST_PACK) || (CNT_W'(dst_ff) <= src_ff), "gst: compaction write overtook the read")
   `ASSERT_ALWAYS(a_strobe_source, clock, reset, !rsp_strobe || $past(accept || (state_ff != ST_IDLE)), "gst: result without an item")

endmodule
